[rtl/rwc_pkg.sv]
package rwc_pkg;

    localparam int PIX_W = 24;
    localparam int NUM_TAPS = 9;

    typedef enum logic [2:0] {
        REG_IMG_WIDTH = 3'd0,
        REG_IMG_HEIGHT = 3'd1,
        REG_KERNEL_SIZE = 3'd2,
        REG_COEF_LOW = 3'd3,
        REG_COEF_MID = 3'd4,
        REG_COEF_LAST = 3'd5
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

[rtl/rwc_stream_if.sv]
interface rwc_stream_if #(
    parameter int DATA_W = 25
);
    logic valid;
    logic ready;
    logic [DATA_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/rwc_lane.sv]
module rwc_lane #(
    parameter int FRAC = 12
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [8:0][7:0]       i_px,
    input  logic [8:0][15:0]      i_coef,
    input  logic [8:0]            i_mask,
    output logic [7:0]            o_val
);
    import rwc_pkg::*;

    logic signed [24:0] r_prod [9];
    logic signed [29:0] n_sum;
    logic signed [29:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int t = 0; t < NUM_TAPS; t++) begin
                r_prod[t] <= i_mask[t]
                    ? 25'($signed({1'b0, i_px[t]})) * 25'($signed(i_coef[t])) : 25'sd0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            n_sum = n_sum + 30'(r_prod[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    logic [29:0] w_shift;
    assign w_shift = 30'(r_sum) >> FRAC;

    always_comb begin
        if (r_sum < 0) begin
            o_val = 8'd0;
        end else if (w_shift > 30'd255) begin
            o_val = 8'd255;
        end else begin
            o_val = w_shift[7:0];
        end
    end
endmodule

[rtl/rgb_window_convolution_top.sv]
// Zero-padded RGB convolution over a raster stream, kernel up to 3x3. One
// beat is accepted per clock with no bubbles while the output is not stalled;
// three per-channel lanes each form nine products in parallel and a registered
// adder tree merges them; a result passes the stage A and stage B registers and
// the lane's product and sum registers. The result for pixel o leaves on the beat
// carrying position o+W+1; send drain beats (req_type=1) after the frame to flush
// the last W+1 results. Two line buffers (one write and one registered read per
// cycle) hold earlier rows; their contents are never used before written.
// Writing width or height restarts the frame. Input data {req,blue,green,red},
// output {frame_last,blue,green,red}.
module rgb_window_convolution_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    rwc_stream_if.sink   s_in,
    rwc_stream_if.source m_out
);
    import rwc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = WW + HW;

    logic [10:0] r_w_cfg, r_h_cfg;
    logic [1:0]  r_k;
    logic [63:0] r_clo, r_cmid;
    logic [15:0] r_clast;

    logic [WW-1:0] w_w;
    logic [HW-1:0] w_h;
    assign w_w = (r_w_cfg == 11'd0) ? WW'(1)
               : (32'(r_w_cfg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_w_cfg);
    assign w_h = (r_h_cfg == 11'd0) ? HW'(1)
               : (32'(r_h_cfg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_h_cfg);

    logic w_restart;
    assign w_restart = i_cfg_we && (i_cfg_idx == REG_IMG_WIDTH || i_cfg_idx == REG_IMG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cfg <= 11'd1024; r_h_cfg <= 11'd1024; r_k <= 2'd3;
            r_clo <= '0; r_cmid <= '0; r_clast <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMG_WIDTH:   r_w_cfg <= i_cfg_data[10:0];
                REG_IMG_HEIGHT:  r_h_cfg <= i_cfg_data[10:0];
                REG_KERNEL_SIZE: r_k <= i_cfg_data[1:0];
                REG_COEF_LOW:    r_clo <= i_cfg_data;
                REG_COEF_MID:    r_cmid <= i_cfg_data;
                REG_COEF_LAST:   r_clast <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances when output slot is free or being drained.
    logic r_ov1, r_ov2, r_ov3;
    logic w_adv;
    assign w_adv = !r_ov3 || m_out.ready;
    assign s_in.ready = w_adv;
    logic w_acc;
    assign w_acc = s_in.valid && s_in.ready;

    // Input position: column, with linear position compared to totals.
    logic [WW-1:0] r_icol;
    logic          r_done;     // all frame pixels arrived
    logic [PW-1:0] r_ipos;
    logic w_drain, w_step;
    assign w_drain = s_in.data[24];
    assign w_step  = w_acc && !(w_drain && !r_done);

    // The beat at position W*H+W carries the final result; restart after it.
    logic [PW-1:0] w_total;
    logic          w_last_in;
    assign w_total   = PW'(w_w) * PW'(w_h);
    assign w_last_in = (r_ipos == w_total + PW'(w_w));

    // Stage A: read line buffers, register pixel. The upper buffer takes the
    // lower buffer's registered read one beat later; bypass it when the next
    // beat reads the same column.
    t_pix r_up_mem [MAX_WIDTH];
    t_pix r_lo_mem [MAX_WIDTH];
    t_pix r_up_rd, r_lo_rd, r_pix_a;
    logic r_va, r_emit_a;
    logic [CW-1:0] w_col;
    assign w_col = CW'(r_icol);
    t_pix w_pix;
    assign w_pix = r_done ? '0 : s_in.data[23:0];
    logic [CW-1:0] r_wb_col;
    logic          r_wb_pend;

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_up_rd <= (r_wb_pend && r_wb_col == w_col) ? r_lo_rd : r_up_mem[w_col];
            r_lo_rd <= r_lo_mem[w_col];
            if (r_wb_pend) r_up_mem[r_wb_col] <= r_lo_rd;
            r_lo_mem[w_col] <= w_pix;
            r_pix_a <= w_pix;
            r_wb_col <= w_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_pend <= 1'b0;
        end else if (w_step) begin
            r_wb_pend <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_icol <= '0; r_done <= 1'b0; r_ipos <= '0;
            r_va <= 1'b0; r_emit_a <= 1'b0;
        end else if (w_adv) begin
            r_va <= w_step;
            r_emit_a <= w_step && (r_ipos >= PW'(w_w) + PW'(1));
            if (w_step) begin
                if (w_last_in) begin
                    r_icol <= '0; r_done <= 1'b0; r_ipos <= '0;
                end else begin
                    r_ipos <= r_ipos + PW'(1);
                    if (r_ipos + PW'(1) >= w_total) r_done <= 1'b1;
                    if (r_icol + WW'(1) >= w_w) begin
                        r_icol <= '0;
                    end else begin
                        r_icol <= r_icol + WW'(1);
                    end
                end
            end
        end
    end

    // Stage B: shift the window and build masks for the emitted output.
    t_pix r_win [3][3];
    logic [WW-1:0] r_ocol;
    logic [HW-1:0] r_orow;
    logic [8:0]    r_mask;
    logic          r_last_b;
    logic          r_emit_a_last;
    assign r_emit_a_last = (r_orow == w_h - HW'(1)) && (r_ocol == w_w - WW'(1)) && r_emit_a
                           && r_va;

    logic [1:0] w_k;
    assign w_k = (r_k > 2'd3) ? 2'd3 : r_k;
    logic [1:0] w_c;
    assign w_c = w_k >> 1;

    logic [8:0]       n_mask;
    logic [8:0][15:0] n_coef;
    logic [8:0][15:0] r_coef;
    logic [143:0] w_bank;
    assign w_bank = {r_clast, r_cmid, r_clo};

    always_comb begin
        logic [1:0] wr, wc;
        logic signed [HW+1:0] pr;
        logic signed [WW+1:0] pc;
        logic [3:0] ci;
        n_mask = '0;
        n_coef = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                wr = 2'(r + 1) - w_c;
                wc = 2'(c + 1) - w_c;
                pr = $signed({2'b00, r_orow}) + $signed((HW+2)'(wr)) - (HW+2)'(1);
                pc = $signed({2'b00, r_ocol}) + $signed((WW+2)'(wc)) - (WW+2)'(1);
                ci = 4'(r) * 4'(w_k) + 4'(c);
                if (r < w_k && c < w_k && pr >= 0 && pr < $signed({2'b00, w_h})
                    && pc >= 0 && pc < $signed({2'b00, w_w})) begin
                    n_mask[int'(wr) * 3 + int'(wc)] = 1'b1;
                    n_coef[int'(wr) * 3 + int'(wc)] = w_bank[16*ci +: 16];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) r_win[r][c] <= '0;
        end else if (w_adv && r_va) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_lo_rd;
            r_win[2][2] <= r_pix_a;
        end
        if (w_adv) begin
            r_mask <= n_mask;
            r_coef <= n_coef;
            r_last_b <= r_emit_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_ocol <= '0; r_orow <= '0; r_ov1 <= 1'b0;
        end else if (w_adv) begin
            r_ov1 <= r_va && r_emit_a;
            if (r_va && r_emit_a) begin
                if (r_emit_a_last) begin
                    r_ocol <= '0; r_orow <= '0;
                end else if (r_ocol + WW'(1) >= w_w) begin
                    r_ocol <= '0; r_orow <= r_orow + HW'(1);
                end else begin
                    r_ocol <= r_ocol + WW'(1);
                end
            end
        end
    end

    // Stage C onward: lanes multiply (C) and sum (D); clamp on output.
    logic [2:0][8:0][7:0] w_lpx;
    always_comb begin
        for (int ch = 0; ch < 3; ch++)
            for (int t = 0; t < 9; t++)
                w_lpx[ch][t] = r_win[t/3][t%3][8*ch +: 8];
    end

    logic [2:0][7:0] w_val;
    for (genvar g = 0; g < 3; g++) begin : g_lane
        rwc_lane #(.FRAC(COEF_FRAC_BITS)) u_lane (
            .i_clk (i_clk), .i_en (w_adv), .i_px (w_lpx[g]),
            .i_coef (r_coef), .i_mask (r_mask), .o_val (w_val[g])
        );
    end

    logic r_last2, r_last3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov2 <= 1'b0; r_ov3 <= 1'b0;
        end else if (w_adv) begin
            r_ov2 <= r_ov1; r_ov3 <= r_ov2;
        end
        if (w_adv) begin
            r_last2 <= r_last_b; r_last3 <= r_last2;
        end
    end

    assign m_out.valid = r_ov3;
    assign m_out.data = {r_last3, w_val[2], w_val[1], w_val[0]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> $stable(m_out.data)) else $error("out moved");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov3 |-> s_in.ready) else $error("stall without result");
    a_lastv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov1 && w_adv) |=> r_ov2) else $error("lost beat");
`endif
endmodule
